>>> src/ymodem_block_receiver_defines.svh
// assertion macros for the ymodem block receiver port checker
`ifndef YMODEM_BLOCK_RECEIVER_DEFINES_SVH
`define YMODEM_BLOCK_RECEIVER_DEFINES_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define YMBR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define YMBR_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/ymbr_pkg.sv
// types, protocol codes and crc step for the ymodem block receiver
package ymbr_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] crc_type;
   typedef logic [9:0]  count_type;
   typedef logic [31:0] total_type;

   typedef enum logic [2:0] {
      PH_HEADER     = 3'd0,
      PH_NUMBER     = 3'd1,
      PH_COMPLEMENT = 3'd2,
      PH_PAYLOAD    = 3'd3,
      PH_CRC_HIGH   = 3'd4,
      PH_CRC_LOW    = 3'd5,
      PH_DONE       = 3'd6
   } phase_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_REPLY   = 1'b1
   } kind_type;

   localparam byte_type CH_SOH = 8'h01;
   localparam byte_type CH_STX = 8'h02;
   localparam byte_type CH_EOT = 8'h04;
   localparam byte_type CH_ACK = 8'h06;
   localparam byte_type CH_NAK = 8'h15;
   localparam byte_type NUM_CHECK = 8'hFF;
   localparam byte_type BYTE_ZERO = 8'h00;

   localparam crc_type   CRC_POLY   = 16'h1021;
   localparam count_type SHORT_LAST = 10'd127;
   localparam count_type LONG_LAST  = 10'd1023;
   localparam total_type SHORT_LEN  = 32'd128;
   localparam total_type LONG_LEN   = 32'd1024;

   // crc-16/xmodem over one byte, msb first
   function automatic crc_type crc_step(crc_type crc, byte_type b);
      crc_type c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> src/ymbr_if.sv
// valid/ready channels for received bytes and for result beats
interface ymbr_req_if;
   import ymbr_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ymbr_rsp_if;
   import ymbr_pkg::*;

   logic      valid;
   logic      ready;
   kind_type  kind;
   byte_type  payload_byte;
   byte_type  reply_byte;
   total_type total_bytes;
   logic      finished;

   modport source (output valid, output kind, output payload_byte, output reply_byte,
                   output total_bytes, output finished, input ready);
   modport sink   (input valid, input kind, input payload_byte, input reply_byte,
                   input total_bytes, input finished, output ready);
endinterface

>>> src/ymodem_block_receiver.sv
// ymodem block receiver: byte-wise block parser with crc-16 check and ack/nak replies
// Takes one received serial byte per clock and answers with at most one result beat:
// payload bytes pass straight through, and each block, cancel, bad header or end of
// transfer produces an ack or nak reply with the running count of accepted payload
// bytes. A byte is taken in every cycle as long as the result register is empty or
// is being emptied in the same cycle; its result shows on the next cycle, and
// throughput is one byte per clock while that holds, set by the single result register
// behind the header decode, one unrolled crc byte step and the 32-bit byte total add.
// Once an end of transfer has been acknowledged, further bytes are taken and dropped.
module ymodem_block_receiver (
   input  logic              clock,
   input  logic              reset,
   ymbr_req_if.sink          req_chan,
   ymbr_rsp_if.source        rsp_chan
);
   import ymbr_pkg::*;

   phase_type phase_ff, phase_in;
   logic      long_ff, long_in;
   byte_type  number_ff, number_in;
   count_type count_ff, count_in;
   crc_type   crc_ff, crc_in;
   byte_type  crc_high_ff, crc_high_in;
   total_type total_ff, total_in;

   logic      rsp_valid_ff, rsp_valid_in;
   kind_type  kind_ff, kind_in;
   byte_type  payload_ff, payload_in;
   byte_type  reply_ff, reply_in;
   total_type rsp_total_ff;
   logic      finished_ff;

   logic      req_fire;
   logic      has_result;
   logic      number_ok;
   logic      crc_ok;
   count_type last_index;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign number_ok  = (number_ff ^ req_chan.rx_byte) == NUM_CHECK;
   assign crc_ok     = {crc_high_ff, req_chan.rx_byte} == crc_ff;
   assign last_index = long_ff ? LONG_LAST : SHORT_LAST;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (req_fire) begin
         unique case (phase_ff)
            PH_NUMBER:     phase_in = PH_COMPLEMENT;
            PH_COMPLEMENT: phase_in = number_ok ? PH_PAYLOAD : PH_HEADER;
            PH_PAYLOAD:    phase_in = (count_ff >= last_index) ? PH_CRC_HIGH : PH_PAYLOAD;
            PH_CRC_HIGH:   phase_in = PH_CRC_LOW;
            PH_CRC_LOW:    phase_in = PH_HEADER;
            PH_DONE:       phase_in = PH_DONE;
            default: begin
               priority if (req_chan.rx_byte == CH_SOH || req_chan.rx_byte == CH_STX) begin
                  phase_in = PH_NUMBER;
               end else if (req_chan.rx_byte == CH_EOT) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_HEADER;
               end
            end
         endcase
      end
   end

   // block state and result beat
   always_comb begin
      long_in     = long_ff;
      number_in   = number_ff;
      count_in    = count_ff;
      crc_in      = crc_ff;
      crc_high_in = crc_high_ff;
      total_in    = total_ff;
      has_result  = 1'b0;
      kind_in     = KIND_REPLY;
      payload_in  = BYTE_ZERO;
      reply_in    = BYTE_ZERO;
      unique case (phase_ff)
         PH_NUMBER: begin
            number_in = req_chan.rx_byte;
         end
         PH_COMPLEMENT: begin
            if (number_ok) begin
               crc_in   = '0;
               count_in = '0;
            end else begin
               has_result = 1'b1;
               reply_in   = CH_NAK;
            end
         end
         PH_PAYLOAD: begin
            crc_in     = crc_step(crc_ff, req_chan.rx_byte);
            count_in   = (count_ff >= last_index) ? '0 : count_ff + 10'd1;
            has_result = 1'b1;
            kind_in    = KIND_PAYLOAD;
            payload_in = req_chan.rx_byte;
         end
         PH_CRC_HIGH: begin
            crc_high_in = req_chan.rx_byte;
         end
         PH_CRC_LOW: begin
            has_result = 1'b1;
            if (crc_ok) begin
               total_in = total_ff + (long_ff ? LONG_LEN : SHORT_LEN);
               reply_in = CH_ACK;
            end else begin
               reply_in = CH_NAK;
            end
         end
         PH_DONE: begin
            has_result = 1'b0;
         end
         default: begin
            priority if (req_chan.rx_byte == CH_SOH || req_chan.rx_byte == CH_STX) begin
               long_in = req_chan.rx_byte == CH_STX;
            end else if (req_chan.rx_byte == CH_EOT) begin
               has_result = 1'b1;
               reply_in   = CH_ACK;
            end else begin
               has_result = 1'b1;
               reply_in   = CH_NAK;
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (req_fire && has_result) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         long_ff      <= 1'b0;
         number_ff    <= '0;
         count_ff     <= '0;
         crc_ff       <= '0;
         crc_high_ff  <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            phase_ff    <= phase_in;
            long_ff     <= long_in;
            number_ff   <= number_in;
            count_ff    <= count_in;
            crc_ff      <= crc_in;
            crc_high_ff <= crc_high_in;
            total_ff    <= total_in;
         end
      end
   end

   // result payload, loaded only with a new beat
   always_ff @(posedge clock) begin
      if (req_fire && has_result) begin
         kind_ff      <= kind_in;
         payload_ff   <= payload_in;
         reply_ff     <= reply_in;
         rsp_total_ff <= total_in;
         finished_ff  <= phase_in == PH_DONE;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = kind_ff;
   assign rsp_chan.payload_byte = payload_ff;
   assign rsp_chan.reply_byte   = reply_ff;
   assign rsp_chan.total_bytes  = rsp_total_ff;
   assign rsp_chan.finished     = finished_ff;

endmodule

>>> src/ymbr_checker.sv
// port-level checks for the ymodem block receiver and their bind
`include "ymodem_block_receiver_defines.svh"

module ymbr_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input ymbr_pkg::kind_type   rsp_kind,
   input ymbr_pkg::byte_type   rsp_payload_byte,
   input ymbr_pkg::byte_type   rsp_reply_byte,
   input ymbr_pkg::total_type  rsp_total_bytes,
   input logic                 rsp_finished
);
   import ymbr_pkg::*;

   `YMBR_ASSERT_IMP(a_payload_no_reply, rsp_valid && rsp_kind == KIND_PAYLOAD, rsp_reply_byte == BYTE_ZERO && !rsp_finished, "payload beat carries a reply or finished flag")
   `YMBR_ASSERT_IMP(a_reply_code, rsp_valid && rsp_kind == KIND_REPLY, rsp_payload_byte == BYTE_ZERO && (rsp_reply_byte == CH_ACK || rsp_reply_byte == CH_NAK), "reply beat is not a clean ack or nak")
   `YMBR_ASSERT_IMP(a_total_whole_blocks, rsp_valid, rsp_total_bytes[6:0] == 7'd0, "byte total is not a whole number of short blocks")
   `YMBR_ASSERT_NXT(a_silent_after_done, rsp_valid && rsp_ready && rsp_finished, !rsp_valid, "result beat after end of transfer")
   `YMBR_ASSERT_NXT(a_stall_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_reply_byte) && $stable(rsp_payload_byte) && $stable(rsp_total_bytes), "stalled result beat changed")

endmodule

bind ymodem_block_receiver ymbr_checker u_ymbr_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_kind         (rsp_chan.kind),
   .rsp_payload_byte (rsp_chan.payload_byte),
   .rsp_reply_byte   (rsp_chan.reply_byte),
   .rsp_total_bytes  (rsp_chan.total_bytes),
   .rsp_finished     (rsp_chan.finished)
);

>>> dv/ymodem_block_receiver_checker.sv
`timescale 1ns / 1ps
// checker: predicts ymodem block receiver result beats and compares them
module ymodem_block_receiver_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  ymbr_pkg::byte_type  req_rx_byte,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  ymbr_pkg::kind_type  rsp_kind,
   input  ymbr_pkg::byte_type  rsp_payload_byte,
   input  ymbr_pkg::byte_type  rsp_reply_byte,
   input  ymbr_pkg::total_type rsp_total_bytes,
   input  logic                rsp_finished,
   output int                  fail_count,
   output int                  outstanding
);
   import ymbr_pkg::*;

   typedef struct {
      kind_type  kind;
      byte_type  payload_byte;
      byte_type  reply_byte;
      total_type total_bytes;
      logic      finished;
   } beat_type;

   beat_type  expected_beats[$];
   int        errors;
   phase_type phase;
   logic      long_block;
   byte_type  block_num;
   count_type data_index;
   crc_type   block_crc;
   byte_type  crc_hi;
   total_type good_total;

   assign fail_count = errors;

   function automatic crc_type crc_next(crc_type crc, byte_type b);
      crc_type c;
      logic    fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c = c << 1;
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("error at %0t: %s is %0h, predicted %0h", $time, what, got, want);
      errors++;
   endtask

   task automatic queue_beat(kind_type kind, byte_type data, byte_type reply);
      beat_type e;
      e.kind = kind;
      e.payload_byte = data;
      e.reply_byte = reply;
      e.total_bytes = good_total;
      e.finished = (phase == PH_DONE);
      expected_beats.push_back(e);
   endtask

   task automatic parse_byte(byte_type b);
      case (phase)
         PH_NUMBER: begin
            block_num = b;
            phase = PH_COMPLEMENT;
         end
         PH_COMPLEMENT: begin
            if ((block_num ^ b) != NUM_CHECK) begin
               phase = PH_HEADER;
               queue_beat(KIND_REPLY, BYTE_ZERO, CH_NAK);
            end else begin
               block_crc = '0;
               data_index = '0;
               phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            block_crc = crc_next(block_crc, b);
            if (data_index >= (long_block ? LONG_LAST : SHORT_LAST)) begin
               data_index = '0;
               phase = PH_CRC_HIGH;
            end else begin
               data_index = data_index + 10'd1;
            end
            queue_beat(KIND_PAYLOAD, b, BYTE_ZERO);
         end
         PH_CRC_HIGH: begin
            crc_hi = b;
            phase = PH_CRC_LOW;
         end
         PH_CRC_LOW: begin
            phase = PH_HEADER;
            if ({crc_hi, b} == block_crc) begin
               good_total = good_total + (long_block ? LONG_LEN : SHORT_LEN);
               queue_beat(KIND_REPLY, BYTE_ZERO, CH_ACK);
            end else begin
               queue_beat(KIND_REPLY, BYTE_ZERO, CH_NAK);
            end
         end
         PH_DONE: begin
         end
         default: begin
            phase = PH_HEADER;
            if (b == CH_SOH || b == CH_STX) begin
               long_block = (b == CH_STX);
               phase = PH_NUMBER;
            end else if (b == CH_EOT) begin
               phase = PH_DONE;
               queue_beat(KIND_REPLY, BYTE_ZERO, CH_ACK);
            end else begin
               queue_beat(KIND_REPLY, BYTE_ZERO, CH_NAK);
            end
         end
      endcase
   endtask

   initial begin
      errors = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      beat_type want;
      if (reset) begin
         phase = PH_HEADER;
         long_block = 1'b0;
         block_num = '0;
         data_index = '0;
         block_crc = '0;
         crc_hi = '0;
         good_total = '0;
         expected_beats.delete();
         outstanding <= 0;
      end else begin
         // result of an earlier byte leaves before this cycle's byte is parsed
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (expected_beats.size() == 0) begin
               report_mismatch("unpredicted result beat", 1, 0);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch("kind", 32'(rsp_kind), 32'(want.kind));
               if (rsp_payload_byte !== want.payload_byte)
                  report_mismatch("payload_byte", 32'(rsp_payload_byte),
                                  32'(want.payload_byte));
               if (rsp_reply_byte !== want.reply_byte)
                  report_mismatch("reply_byte", 32'(rsp_reply_byte), 32'(want.reply_byte));
               if (rsp_total_bytes !== want.total_bytes)
                  report_mismatch("total_bytes", rsp_total_bytes, want.total_bytes);
               if (rsp_finished !== want.finished)
                  report_mismatch("finished", 32'(rsp_finished), 32'(want.finished));
            end
         end
         if (req_valid === 1'b1 && req_ready === 1'b1) begin
            parse_byte(req_rx_byte);
         end
         outstanding <= expected_beats.size();
      end
   end

endmodule

>>> dv/ymodem_block_receiver_tb.sv
`timescale 1ns / 1ps
// testbench top: byte stimulus, result back-pressure and verdict for the block receiver
module ymodem_block_receiver_tb;
   import ymbr_pkg::*;

   localparam byte_type CH_CAN    = 8'h18;
   localparam int       ITEM_GOAL = 2000;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   outstanding;
   int   sent;
   int   idle_odds;
   bit   calm;

   ymbr_req_if req_if ();
   ymbr_rsp_if rsp_if ();

   ymodem_block_receiver dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   ymodem_block_receiver_checker reply_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_if.valid),
      .req_ready        (req_if.ready),
      .req_rx_byte      (req_if.rx_byte),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_kind         (rsp_if.kind),
      .rsp_payload_byte (rsp_if.payload_byte),
      .rsp_reply_byte   (rsp_if.reply_byte),
      .rsp_total_bytes  (rsp_if.total_bytes),
      .rsp_finished     (rsp_if.finished),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic crc_type block_crc_update(crc_type crc, byte_type b);
      crc_type c;
      c = crc ^ {b, 8'h00};
      repeat (8) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   task automatic send_byte(byte_type b);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.rx_byte <= b;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      sent++;
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic send_block(bit long_block, bit crc_ok);
      byte_type num;
      byte_type b;
      crc_type  crc;
      int       len;
      num = byte_type'($urandom_range(0, 255));
      len = long_block ? 1024 : 128;
      crc = '0;
      send_byte(long_block ? CH_STX : CH_SOH);
      send_byte(num);
      send_byte(~num);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 9))
            0: b = 8'h00;
            1: b = 8'hFF;
            default: b = byte_type'($urandom_range(0, 255));
         endcase
         crc = block_crc_update(crc, b);
         send_byte(b);
      end
      if (!crc_ok) begin
         crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      end
      send_byte(crc[15:8]);
      send_byte(crc[7:0]);
   endtask

   task automatic send_bad_number();
      byte_type num;
      num = byte_type'($urandom_range(0, 255));
      send_byte($urandom_range(0, 1) ? CH_STX : CH_SOH);
      send_byte(num);
      send_byte(~num ^ byte_type'($urandom_range(1, 255)));
   endtask

   task automatic send_noise();
      byte_type b;
      repeat ($urandom_range(1, 3)) begin
         b = byte_type'($urandom_range(0, 255));
         if (b == CH_SOH || b == CH_STX || b == CH_EOT) begin
            b = CH_CAN;
         end
         send_byte(b);
      end
   endtask

   task automatic pick_idle_odds();
      if (calm) begin
         idle_odds = 0;
      end else begin
         case ($urandom_range(0, 3))
            0: idle_odds = 0;
            1: idle_odds = 3;
            2: idle_odds = 8;
            default: idle_odds = 20;
         endcase
      end
   endtask

   // result side back-pressure
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (idle_odds != 0 && !calm && $urandom_range(1, idle_odds) == 1) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin
      int r;
      sent = 0;
      calm = 1'b0;
      idle_odds = 8;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.rx_byte <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // unknown and cancel headers, then bad block numbers
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CH_CAN);
      send_byte(8'h03);
      send_byte(CH_ACK);
      send_byte(CH_NAK);
      send_byte(CH_SOH);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(CH_STX);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(CH_SOH);
      send_byte(8'h5A);
      send_byte(8'h5B);
      drain_results();

      send_block(1'b1, 1'b1);
      while (sent < ITEM_GOAL) begin
         if (sent >= ITEM_GOAL - 300) begin
            calm = 1'b1;
         end
         pick_idle_odds();
         r = $urandom_range(0, 99);
         if (r < 5 && sent < ITEM_GOAL - 900) begin
            send_block(1'b1, $urandom_range(0, 3) != 0);
         end else if (r < 62) begin
            send_block(1'b0, $urandom_range(0, 4) != 0);
         end else if (r < 78) begin
            send_bad_number();
         end else begin
            send_noise();
         end
         if ($urandom_range(0, 19) == 0) begin
            drain_results();
         end
      end

      // end of transfer, then bytes that must be dropped
      calm = 1'b1;
      idle_odds = 0;
      send_byte(CH_EOT);
      send_byte(CH_SOH);
      send_byte(CH_EOT);
      repeat (12) send_byte(byte_type'($urandom_range(0, 255)));

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("ymodem_block_receiver: match");
      end else begin
         $display("ymodem_block_receiver: mismatch");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("ymodem_block_receiver: mismatch");
      $finish;
   end

endmodule

>>> sim.f
+incdir+src
src/ymbr_pkg.sv
src/ymbr_if.sv
src/ymodem_block_receiver.sv
src/ymbr_checker.sv
dv/ymodem_block_receiver_checker.sv
dv/ymodem_block_receiver_tb.sv
